[src/dtrtc_pkg.sv]
// shared constants and helper functions for the timestamp to bcd converter
`default_nettype none
package dtrtc_pkg;

  localparam int STAMP_W = 32;

  // year offset codes at which the century changes (2000 and 2100)
  localparam logic [6:0] Y2000 = 7'd20;
  localparam logic [6:0] Y2100 = 7'd120;
  localparam logic [6:0] Y2101 = 7'd121;

  // century digits in bcd
  localparam logic [5:0] CENT_19 = 6'h19;
  localparam logic [5:0] CENT_20 = 6'h20;
  localparam logic [5:0] CENT_21 = 6'h21;

  // binary 0..99 (or up to 127) to two bcd digits, divide by ten by reciprocal
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(v) * 15'd205;
    q    = prod[14:11];
    r    = v - 7'(q) * 7'd10;
    return {q, r[3:0]};
  endfunction

  // residue modulo 7 by folding octal digits (8 is 1 mod 7)
  function automatic logic [2:0] mod7(input logic [7:0] v);
    logic [4:0] d;
    logic [3:0] e;
    d = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[7:6]);
    e = 4'(d[2:0]) + 4'(d[4:3]);
    if (e >= 4'd7) begin
      e = e - 4'd7;
    end
    return e[2:0];
  endfunction

  // days before the first of the month, modulo 7
  function automatic logic [2:0] month_offset(input logic [3:0] month, input logic leap);
    logic [2:0] base;
    unique case (month)
      4'd1:    base = 3'd0;
      4'd2:    base = 3'd3;
      4'd3:    base = 3'd3;
      4'd4:    base = 3'd6;
      4'd5:    base = 3'd1;
      4'd6:    base = 3'd4;
      4'd7:    base = 3'd6;
      4'd8:    base = 3'd2;
      4'd9:    base = 3'd5;
      4'd10:   base = 3'd0;
      4'd11:   base = 3'd3;
      4'd12:   base = 3'd5;
      default: base = 3'd0;
    endcase
    if (leap && month >= 4'd3) begin
      base = base + 3'd1;
    end
    return base;
  endfunction

endpackage
`default_nettype wire

[src/dos_datetime_to_rtc_bcd.sv]
// packed fat timestamp to bcd real-time-clock register image, three-stage pipeline
//
// usage: drive dos_stamp and raise start for one cycle per word. busy is
// always low, so a new word may be started in every clock cycle.
// each word produces one result word on the result ports, marked by done
// for exactly one cycle. throughput is one word per cycle; the three
// register stages are unpack and year base, bcd conversion and day sum,
// weekday residue.
// the receiver cannot hold results off; it must take each word in the
// cycle done is high.
// a month of 0 or 13..15 sets month_invalid and gives weekday 0; all other
// fields are still converted.
// rst (synchronous, active high) clears the stage valid bits, so no
// result appears until a new word is started.
`default_nettype none
module dos_datetime_to_rtc_bcd (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [dtrtc_pkg::STAMP_W-1:0] dos_stamp,
  output logic                              done,
  output logic [6:0]                        sec_bcd,
  output logic [6:0]                        min_bcd,
  output logic [5:0]                        hour_bcd,
  output logic [5:0]                        mday_bcd,
  output logic [2:0]                        wday_bcd,
  output logic [4:0]                        month_bcd,
  output logic [7:0]                        year_bcd,
  output logic [5:0]                        century_bcd,
  output logic                              month_invalid
);
  import dtrtc_pkg::*;

  // stage 1 registers
  logic       v1;
  logic [4:0] s1_sec2, s1_mday, s1_hour;
  logic [5:0] s1_min;
  logic [3:0] s1_month;
  logic [6:0] s1_yr;
  logic [5:0] s1_cent;
  logic [7:0] s1_base;
  logic [2:0] s1_moff;
  logic       s1_bad;

  // stage 2 registers
  logic       v2;
  logic [6:0] s2_sec, s2_min;
  logic [5:0] s2_hour, s2_mday, s2_cent;
  logic [4:0] s2_month;
  logic [7:0] s2_year;
  logic [7:0] s2_total;
  logic       s2_bad;

  // stage 1 combinational
  logic [6:0] y7;
  logic [7:0] yq_sum;
  logic [7:0] base_next;
  logic       leap;
  logic [6:0] yr_next;
  logic [5:0] cent_next;
  logic [3:0] month_raw;

  assign busy = 1'b0;

  assign y7        = dos_stamp[31:25];
  assign month_raw = dos_stamp[24:21];
  assign yq_sum    = 8'(y7) + 8'd3;
  // days up to the end of the previous year, only its residue mod 7 matters
  assign base_next = 8'(y7) + 8'(yq_sum[7:2]) + ((y7 >= Y2101) ? 8'd0 : 8'd1);
  assign leap      = (y7[1:0] == 2'b00) && (y7 != Y2100);

  always_comb begin
    if (y7 < Y2000) begin
      yr_next   = y7 + 7'd80;
      cent_next = CENT_19;
    end else if (y7 < Y2100) begin
      yr_next   = y7 - Y2000;
      cent_next = CENT_20;
    end else begin
      yr_next   = y7 - Y2100;
      cent_next = CENT_21;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s1_sec2  <= dos_stamp[4:0];
    s1_min   <= dos_stamp[10:5];
    s1_hour  <= dos_stamp[15:11];
    s1_mday  <= dos_stamp[20:16];
    s1_month <= month_raw;
    s1_yr    <= yr_next;
    s1_cent  <= cent_next;
    s1_base  <= base_next;
    s1_moff  <= month_offset(month_raw, leap);
    s1_bad   <= (month_raw == 4'd0) || (month_raw > 4'd12);
  end

  // stage 2: bcd conversion and day sum
  logic [7:0] sec_b, min_b, hour_b, mday_b, month_b, year_b;
  assign sec_b   = to_bcd({1'b0, s1_sec2, 1'b0});
  assign min_b   = to_bcd(7'(s1_min));
  assign hour_b  = to_bcd(7'(s1_hour));
  assign mday_b  = to_bcd(7'(s1_mday));
  assign month_b = to_bcd(7'(s1_month));
  assign year_b  = to_bcd(s1_yr);

  always_ff @(posedge clk) begin
    s2_sec   <= sec_b[6:0];
    s2_min   <= min_b[6:0];
    s2_hour  <= hour_b[5:0];
    s2_mday  <= mday_b[5:0];
    s2_month <= month_b[4:0];
    s2_year  <= year_b;
    s2_cent  <= s1_cent;
    s2_total <= 8'(s1_mday) + s1_base + 8'(s1_moff);
    s2_bad   <= s1_bad;
  end

  // stage 3: weekday residue, output register
  always_ff @(posedge clk) begin
    sec_bcd       <= s2_sec;
    min_bcd       <= s2_min;
    hour_bcd      <= s2_hour;
    mday_bcd      <= s2_mday;
    month_bcd     <= s2_month;
    year_bcd      <= s2_year;
    century_bcd   <= s2_cent;
    month_invalid <= s2_bad;
    wday_bcd      <= s2_bad ? 3'd0 : mod7(s2_total) + 3'd1;
  end

endmodule
`default_nettype wire
